// ----- rtl/core/dynamic_rate_audio_resampling_fifo_assert.svh -----
// Assertion macros for the resampling FIFO checker.
`ifndef DYNAMIC_RATE_AUDIO_RESAMPLING_FIFO_ASSERT_SVH
`define DYNAMIC_RATE_AUDIO_RESAMPLING_FIFO_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DRARF_AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drarf assertion failed");

// next-cycle implication, disabled during reset
`define DRARF_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drarf assertion failed");

// next-cycle implication that also holds across reset
`define DRARF_AST_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("drarf assertion failed");

`endif

// ----- rtl/core/drarf_pkg.sv -----
// Shared constants and types for the dynamic-rate resampling FIFO.
package drarf_pkg;

  localparam int RING_FRAMES = 16384;
  localparam int RING_AW     = $clog2(RING_FRAMES);
  localparam int WORD_W      = 32;
  localparam int SAMP_W      = 16;
  localparam int BATCH_W     = 15;
  localparam int FILL_W      = 14;
  localparam int BUD_W       = (RING_AW + 1 > BATCH_W) ? RING_AW + 1 : BATCH_W;

  // phase and step, unsigned Q2.20
  localparam int QBITS = 20;
  localparam int PH_W  = 22;
  localparam logic [PH_W-1:0] QONE = PH_W'(1 << QBITS);

  // rate divider: quotient = (200*RING << 20) / n, n in [190*RING, 210*RING]
  localparam int DEN_W = RING_AW + 8;
  localparam int QUO_W = 21;
  localparam int DCNT_W = $clog2(QUO_W + 1);
  localparam logic [DEN_W-1:0] DIV_HI = DEN_W'((200 * RING_FRAMES) >> (QUO_W - QBITS));
  localparam logic [DEN_W-1:0] N_201  = DEN_W'(201 * RING_FRAMES);
  localparam logic [DEN_W-1:0] N_196  = DEN_W'(196 * RING_FRAMES);
  localparam logic [DEN_W-1:0] N_190  = DEN_W'(190 * RING_FRAMES);
  localparam logic [DEN_W-1:0] N_210  = DEN_W'(210 * RING_FRAMES);

  // interpolation sum: 17-bit difference times 21-bit phase plus prev << 20
  localparam int SUM_W = 38;
  localparam logic [SUM_W-1:0] TRUNC_RND = SUM_W'((1 << QBITS) - 1);

  // configuration register indexes
  localparam logic REG_FAST_FORWARD = 1'b0;
  localparam logic REG_MUTED        = 1'b1;

  // item kinds on in_tuser
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PCHK,
    S_LOOP,
    S_WR,
    S_RD,
    S_RESULT
  } seq_state_t;

endpackage

// ----- rtl/core/drarf_ring_ram.sv -----
// Simple dual-port ring memory with registered read.
module drarf_ring_ram #(
  parameter int AW = 14,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/drarf_step_div.sv -----
// Radix-2 restoring divider producing the resampling step.
module drarf_step_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [drarf_pkg::DEN_W-1:0]    den,
  output logic                           done,
  output logic [drarf_pkg::QUO_W-1:0]    quo
);

  logic [drarf_pkg::DEN_W-1:0]  rem_r;
  logic [drarf_pkg::DEN_W-1:0]  den_r;
  logic [drarf_pkg::QUO_W-1:0]  quo_r;
  logic [drarf_pkg::DCNT_W-1:0] cnt_r;
  logic                         done_r;
  logic [drarf_pkg::DEN_W:0]    trial;
  logic                         ge;

  assign trial = {rem_r, 1'b0};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= drarf_pkg::DCNT_W'(drarf_pkg::QUO_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == drarf_pkg::DCNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder always stays below den, so one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= drarf_pkg::DIV_HI;
      den_r <= den;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? drarf_pkg::DEN_W'(trial - {1'b0, den_r}) : drarf_pkg::DEN_W'(trial);
      quo_r <= {quo_r[drarf_pkg::QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/core/dynamic_rate_audio_resampling_fifo.sv -----
// Top level: sequencer, rate latch and interpolator around the ring memory.
//
//  channel | handshake        | payload
//  in_     | tvalid / tready  | tuser: mode; tdata: left, right, batch_start, batch_frames
//  out_    | tvalid / tready  | tdata: left, right, underrun, dropped, fill_frames
//  cfg_    | we (no wait)     | addr: register index; wdata: value
//
// A push runs S_PCHK, then S_LOOP (multiply) and S_WR (memory write) for
// each of its w ring writes (0..2), then S_RESULT; a push dropped for an
// empty batch budget skips the writes. A batch start that sets a new rate
// first waits in S_DIV for the bit-serial step divider. A pull reads the
// ring in S_RD unless it underruns. One item is in work at a time.
// Reset is synchronous; the ring contents are not cleared. A stalled result
// sits in the output register and the next item may be accepted meanwhile.
module dynamic_rate_audio_resampling_fifo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // left_in, right_in, batch_start, batch_frames
  input  logic [0:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // left_out, right_out, underrun, dropped, fill_frames
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [0:0]  cfg_wdata
);

  localparam int AW = drarf_pkg::RING_AW;
  localparam int SW = drarf_pkg::SAMP_W;

  drarf_pkg::seq_state_t state_r, state_nxt;

  logic [AW-1:0]                  wr_idx_r, rd_idx_r;
  logic [drarf_pkg::PH_W-1:0]     phase_r, step_r;
  logic signed [SW-1:0]           prev_l_r, prev_r_r, new_l_r, new_r_r;
  logic [drarf_pkg::BUD_W-1:0]    in_bud_r, out_bud_r;
  logic                           ff_r, mute_r;
  logic [SW-1:0]                  res_l_r, res_r_r;
  logic                           res_under_r, res_drop_r;
  logic signed [drarf_pkg::SUM_W-1:0] sum_l_r, sum_r_r;
  logic                           out_tvalid_r;
  logic [47:0]                    out_tdata_r;

  // input fields
  logic                          f_mode;
  logic signed [SW-1:0]          f_left, f_right;
  logic                          f_bstart;
  logic [drarf_pkg::BATCH_W-1:0] f_frames;

  assign f_mode   = in_tuser[0];
  assign f_left   = in_tdata[15:0];
  assign f_right  = in_tdata[31:16];
  assign f_bstart = in_tdata[32];
  assign f_frames = in_tdata[47:33];

  logic accept;
  assign accept = in_tvalid && in_tready;

  // rate latch
  logic [AW-1:0]                 avail, free_fr;
  logic [drarf_pkg::BUD_W-1:0]   free_b, frames_b, count;
  logic [drarf_pkg::DEN_W-1:0]   n_raw, n_cap, n_clamp;
  logic                          tight, rate_go;

  assign avail    = wr_idx_r - rd_idx_r;
  assign free_fr  = AW'(drarf_pkg::RING_FRAMES - 1) - avail;
  assign free_b   = drarf_pkg::BUD_W'(free_fr);
  assign frames_b = drarf_pkg::BUD_W'(f_frames);
  assign count    = (ff_r && frames_b > free_b) ? free_b : frames_b;
  assign n_raw    = drarf_pkg::N_201 - (drarf_pkg::DEN_W'(avail) << 1);
  assign tight    = {1'b0, free_b} < {count, 1'b0};
  assign n_cap    = (tight && n_raw > drarf_pkg::N_196) ? drarf_pkg::N_196 : n_raw;

  always_comb begin
    n_clamp = n_cap;
    if (n_cap < drarf_pkg::N_190) begin
      n_clamp = drarf_pkg::N_190;
    end else if (n_cap > drarf_pkg::N_210) begin
      n_clamp = drarf_pkg::N_210;
    end
  end

  assign rate_go = accept && f_mode == drarf_pkg::MODE_PUSH && f_bstart && count != '0;

  // divider
  logic                         div_done;
  logic [drarf_pkg::QUO_W-1:0]  div_quo;

  drarf_step_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rate_go),
    .den   (n_clamp),
    .done  (div_done),
    .quo   (div_quo)
  );

  // interpolation
  logic signed [SW:0]                 diff_l, diff_r;
  logic signed [drarf_pkg::QBITS:0]   ph_s;
  logic signed [drarf_pkg::SUM_W-1:0] base_l, base_r, prod_l, prod_r;
  logic signed [drarf_pkg::SUM_W-1:0] adj_l, adj_r;
  logic [SW-1:0]                      val_l, val_r;
  logic                               phase_ge1;

  assign diff_l    = (SW+1)'(new_l_r) - (SW+1)'(prev_l_r);
  assign diff_r    = (SW+1)'(new_r_r) - (SW+1)'(prev_r_r);
  assign ph_s      = $signed({1'b0, phase_r[drarf_pkg::QBITS-1:0]});
  assign prod_l    = diff_l * ph_s;
  assign prod_r    = diff_r * ph_s;
  assign base_l    = drarf_pkg::SUM_W'(prev_l_r) <<< drarf_pkg::QBITS;
  assign base_r    = drarf_pkg::SUM_W'(prev_r_r) <<< drarf_pkg::QBITS;
  assign phase_ge1 = phase_r >= drarf_pkg::QONE;

  // truncate toward zero
  assign adj_l = sum_l_r + (sum_l_r[drarf_pkg::SUM_W-1] ? drarf_pkg::TRUNC_RND : '0);
  assign adj_r = sum_r_r + (sum_r_r[drarf_pkg::SUM_W-1] ? drarf_pkg::TRUNC_RND : '0);
  assign val_l = adj_l[drarf_pkg::QBITS +: SW];
  assign val_r = adj_r[drarf_pkg::QBITS +: SW];

  // ring memory
  logic                             ram_we, ram_re;
  logic [drarf_pkg::WORD_W-1:0]     ram_rdata;

  assign ram_we = state_r == drarf_pkg::S_WR;
  assign ram_re = accept && f_mode == drarf_pkg::MODE_PULL;

  drarf_ring_ram #(
    .AW (AW),
    .DW (drarf_pkg::WORD_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata ({val_r, val_l}),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drarf_pkg::S_IDLE: begin
        if (accept) begin
          if (f_mode == drarf_pkg::MODE_PULL) begin
            state_nxt = (avail == '0) ? drarf_pkg::S_RESULT : drarf_pkg::S_RD;
          end else begin
            state_nxt = rate_go ? drarf_pkg::S_DIV : drarf_pkg::S_PCHK;
          end
        end
      end
      drarf_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = drarf_pkg::S_PCHK;
        end
      end
      drarf_pkg::S_PCHK: begin
        state_nxt = (in_bud_r == '0) ? drarf_pkg::S_RESULT : drarf_pkg::S_LOOP;
      end
      drarf_pkg::S_LOOP: begin
        if (phase_ge1 || out_bud_r == '0) begin
          state_nxt = drarf_pkg::S_RESULT;
        end else begin
          state_nxt = drarf_pkg::S_WR;
        end
      end
      drarf_pkg::S_WR:     state_nxt = drarf_pkg::S_LOOP;
      drarf_pkg::S_RD:     state_nxt = drarf_pkg::S_RESULT;
      drarf_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = drarf_pkg::S_IDLE;
        end
      end
      default: state_nxt = drarf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    case (state_r)
      drarf_pkg::S_IDLE: in_tready = 1'b1;
      default:           in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drarf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r   <= 1'b0;
      mute_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr[0])
        drarf_pkg::REG_FAST_FORWARD: ff_r   <= cfg_wdata[0];
        drarf_pkg::REG_MUTED:        mute_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // resampler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      phase_r   <= '0;
      step_r    <= drarf_pkg::QONE;
      prev_l_r  <= '0;
      prev_r_r  <= '0;
      in_bud_r  <= '0;
      out_bud_r <= '0;
    end else begin
      case (state_r)
        drarf_pkg::S_IDLE: begin
          if (accept && f_mode == drarf_pkg::MODE_PUSH && f_bstart) begin
            in_bud_r  <= count;
            out_bud_r <= free_b;
          end
        end
        drarf_pkg::S_DIV: begin
          if (div_done) begin
            step_r <= drarf_pkg::PH_W'(div_quo);
          end
        end
        drarf_pkg::S_PCHK: begin
          if (in_bud_r != '0) begin
            in_bud_r <= in_bud_r - 1'b1;
          end
        end
        drarf_pkg::S_LOOP: begin
          if (phase_ge1) begin
            phase_r  <= phase_r - drarf_pkg::QONE;
            prev_l_r <= new_l_r;
            prev_r_r <= new_r_r;
          end else if (out_bud_r == '0) begin
            // drop the rest of the batch
            in_bud_r <= '0;
          end
        end
        drarf_pkg::S_WR: begin
          wr_idx_r  <= wr_idx_r + 1'b1;
          out_bud_r <= out_bud_r - 1'b1;
          phase_r   <= phase_r + step_r;
        end
        drarf_pkg::S_RD: begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // item payload and result under construction
  always_ff @(posedge clk) begin
    case (state_r)
      drarf_pkg::S_IDLE: begin
        if (accept) begin
          new_l_r     <= f_left;
          new_r_r     <= f_right;
          res_l_r     <= '0;
          res_r_r     <= '0;
          res_under_r <= f_mode == drarf_pkg::MODE_PULL && avail == '0;
          res_drop_r  <= 1'b0;
        end
      end
      drarf_pkg::S_PCHK: begin
        if (in_bud_r == '0) begin
          res_drop_r <= 1'b1;
        end
      end
      drarf_pkg::S_LOOP: begin
        if (!phase_ge1 && out_bud_r == '0) begin
          res_drop_r <= 1'b1;
        end
        sum_l_r <= base_l + prod_l;
        sum_r_r <= base_r + prod_r;
      end
      drarf_pkg::S_RD: begin
        if (!mute_r) begin
          res_l_r <= ram_rdata[SW-1:0];
          res_r_r <= ram_rdata[drarf_pkg::WORD_W-1:SW];
        end
      end
      default: ;
    endcase
  end

  // output register
  logic load_out;
  assign load_out = state_r == drarf_pkg::S_RESULT && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {drarf_pkg::FILL_W'(avail), res_drop_r, res_under_r, res_r_r, res_l_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- rtl/core/drarf_checker.sv -----
// Port-level checker for the resampling FIFO, bound to the top level.
`include "dynamic_rate_audio_resampling_fifo_assert.svh"

module drarf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic [31:0] smp;
  logic        under_f, drop_f;
  logic [13:0] fill_f;

  assign smp     = out_tdata[31:0];
  assign under_f = out_tdata[32];
  assign drop_f  = out_tdata[33];
  assign fill_f  = out_tdata[47:34];

  `DRARF_AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `DRARF_AST_IMPL(a_under_empty, out_tvalid && under_f, smp == 32'd0 && !drop_f && fill_f == 14'd0)
  `DRARF_AST_IMPL(a_drop_quiet, out_tvalid && drop_f, smp == 32'd0 && !under_f)
  `DRARF_AST_NEXT(a_one_in_work, in_tvalid && in_tready, !in_tready)
  `DRARF_AST_RST(a_rst_clear, !rst_n, !out_tvalid)

endmodule

bind dynamic_rate_audio_resampling_fifo drarf_checker u_drarf_checker (.*);

// ----- tb/tb_dynamic_rate_audio_resampling_fifo.sv -----
// Self-checking testbench for the dynamic-rate audio resampling FIFO.
module tb_dynamic_rate_audio_resampling_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DIR_ROWS    = 16;
  localparam int     ITEM_GOAL   = 1550;
  localparam int     RAND_ITEMS  = ITEM_GOAL - DIR_ROWS;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     RING        = drarf_pkg::RING_FRAMES;
  localparam int     QB          = drarf_pkg::QBITS;
  localparam longint QUNIT       = 64'd1 << drarf_pkg::QBITS;

  typedef struct packed {
    logic        mode;
    logic [14:0] bframes;
    logic        bstart;
    logic [15:0] rgt;
    logic [15:0] lft;
  } frame_req_t;

  typedef struct packed {
    logic [13:0] fill;
    logic        drop;
    logic        under;
    logic [15:0] rgt;
    logic [15:0] lft;
  } frame_res_t;

  typedef struct {
    frame_req_t req;
    bit         typed;
    frame_res_t res;
  } dir_row_t;

  logic        clk = 0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // left_in, right_in, batch_start, batch_frames
  logic [0:0]  in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // left_out, right_out, underrun, dropped, fill_frames
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [0:0]  cfg_wdata;

  dynamic_rate_audio_resampling_fifo DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]                ring_q [RING];
  int unsigned                wr_ptr, rd_ptr, out_left, in_left;
  logic [drarf_pkg::PH_W-1:0] phase_q, step_q;
  int                         last_l, last_r;
  bit                         ff_q, mute_q;

  frame_res_t expected_q[$];
  dir_row_t   dir_tbl [DIR_ROWS];
  bit         drv_typed;
  frame_res_t drv_res;
  int         mismatches = 0;
  int         cycles = 0;
  int         stall_left = 0;

  function automatic void pred_reset();
    wr_ptr   = 0;
    rd_ptr   = 0;
    phase_q  = '0;
    step_q   = drarf_pkg::QONE;
    last_l   = 0;
    last_r   = 0;
    out_left = 0;
    in_left  = 0;
    ff_q     = 1'b0;
    mute_q   = 1'b0;
  endfunction

  function automatic int unsigned held_frames();
    return (wr_ptr + RING - rd_ptr) % RING;
  endfunction

  function automatic int interp(int a, int b, logic [drarf_pkg::PH_W-1:0] ph);
    longint sum;
    sum = longint'(a) * QUNIT + (longint'(b) - longint'(a)) * longint'(ph);
    if (sum >= 0) return int'(sum >>> QB);
    return -int'((-sum) >>> QB);
  endfunction

  function automatic void latch_rate(input int unsigned frames);
    int unsigned avail, freef, count;
    longint n, cap;
    cap   = RING;
    avail = held_frames();
    freef = RING - 1 - avail;
    count = frames;
    if (ff_q && count > freef) count = freef;
    in_left  = count;
    out_left = freef;
    if (count == 0) return;
    n = 201 * cap - 2 * longint'(avail);
    if (longint'(freef) < 2 * longint'(count) && n > 196 * cap) n = 196 * cap;
    if (n < 190 * cap) n = 190 * cap;
    if (n > 210 * cap) n = 210 * cap;
    step_q = drarf_pkg::PH_W'(((200 * cap) << QB) / n);
  endfunction

  function automatic void resample_step(input frame_req_t req, output frame_res_t res);
    logic [31:0] word;
    int vl, vr, nl, nr;
    res = '0;
    nl  = int'($signed(req.lft));
    nr  = int'($signed(req.rgt));
    if (req.mode == drarf_pkg::MODE_PULL) begin
      if (held_frames() == 0) begin
        res.under = 1'b1;
      end else begin
        word = ring_q[rd_ptr];
        if (!mute_q) begin
          res.lft = word[15:0];
          res.rgt = word[31:16];
        end
        rd_ptr = (rd_ptr + 1) % RING;
      end
    end else begin
      if (req.bstart) latch_rate(int'(req.bframes));
      if (in_left == 0) begin
        res.drop = 1'b1;
      end else begin
        in_left--;
        while (phase_q < drarf_pkg::QONE) begin
          if (out_left == 0) begin
            in_left  = 0;
            res.drop = 1'b1;
            break;
          end
          vl = interp(last_l, nl, phase_q);
          vr = interp(last_r, nr, phase_q);
          ring_q[wr_ptr] = {vr[15:0], vl[15:0]};
          wr_ptr = (wr_ptr + 1) % RING;
          out_left--;
          phase_q = phase_q + step_q;
        end
        if (!res.drop) begin
          phase_q = phase_q - drarf_pkg::QONE;
          last_l  = nl;
          last_r  = nr;
        end
      end
    end
    res.fill = 14'(held_frames());
  endfunction

  function automatic void report_mismatch(frame_res_t exp_r, frame_res_t act_r);
    if (mismatches < 10) begin
      $display("Mismatch: expected l=%0d r=%0d under=%0b drop=%0b fill=%0d",
               $signed(exp_r.lft), $signed(exp_r.rgt), exp_r.under, exp_r.drop, exp_r.fill);
      $display("          actual   l=%0d r=%0d under=%0b drop=%0b fill=%0d",
               $signed(act_r.lft), $signed(act_r.rgt), act_r.under, act_r.drop, act_r.fill);
    end
    mismatches++;
  endfunction

  function automatic frame_req_t push_req(int l, int r, bit bs, int bf);
    frame_req_t q;
    q         = '0;
    q.mode    = drarf_pkg::MODE_PUSH;
    q.lft     = 16'(l);
    q.rgt     = 16'(r);
    q.bstart  = bs;
    q.bframes = 15'(bf);
    return q;
  endfunction

  function automatic frame_req_t pull_req();
    frame_req_t q;
    q      = '0;
    q.mode = drarf_pkg::MODE_PULL;
    return q;
  endfunction

  function automatic frame_res_t flags_res(bit under, bit drop, int fill);
    frame_res_t s;
    s       = '0;
    s.under = under;
    s.drop  = drop;
    s.fill  = 14'(fill);
    return s;
  endfunction

  function automatic void build_table();
    dir_tbl[0]  = '{pull_req(), 1'b1, flags_res(1'b1, 1'b0, 0)};
    dir_tbl[1]  = '{push_req(10, -10, 1'b0, 0), 1'b1, flags_res(1'b0, 1'b1, 0)};
    dir_tbl[2]  = '{push_req(10, -10, 1'b1, 0), 1'b1, flags_res(1'b0, 1'b1, 0)};
    dir_tbl[3]  = '{push_req(1000, -1000, 1'b1, 4), 1'b0, '0};
    dir_tbl[4]  = '{push_req(32767, -32768, 1'b0, 0), 1'b0, '0};
    dir_tbl[5]  = '{push_req(-32768, 32767, 1'b0, 0), 1'b0, '0};
    dir_tbl[6]  = '{push_req(0, 0, 1'b0, 0), 1'b0, '0};
    dir_tbl[7]  = '{push_req(5, 5, 1'b0, 0), 1'b0, '0};
    dir_tbl[8]  = '{pull_req(), 1'b0, '0};
    dir_tbl[9]  = '{pull_req(), 1'b0, '0};
    dir_tbl[10] = '{pull_req(), 1'b0, '0};
    dir_tbl[11] = '{push_req(-1, 1, 1'b1, 16384), 1'b0, '0};
    dir_tbl[12] = '{push_req(123, -456, 1'b1, 32767), 1'b0, '0};
    dir_tbl[13] = '{pull_req(), 1'b0, '0};
    dir_tbl[14] = '{push_req(-32768, -32768, 1'b0, 0), 1'b0, '0};
    dir_tbl[15] = '{pull_req(), 1'b0, '0};
  endfunction

  function automatic int pick_gap();
    int k;
    k = int'($urandom_range(0, 99));
    if (k < 60) return 0;
    if (k < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  function automatic logic [15:0] pick_sample();
    int k;
    k = int'($urandom_range(0, 99));
    if (k < 5) return 16'h8000;
    if (k < 10) return 16'h7FFF;
    return 16'($urandom());
  endfunction

  function automatic logic [14:0] pick_frames();
    int k;
    k = int'($urandom_range(0, 99));
    if (k < 60) return 15'($urandom_range(1, 40));
    if (k < 85) return 15'($urandom_range(41, 16384));
    if (k < 90) return 15'd0;
    if (k < 95) return 15'd16384;
    return 15'd32767;
  endfunction

  function automatic frame_req_t rand_req();
    frame_req_t q;
    q         = '0;
    q.mode    = ($urandom_range(0, 99) < 45) ? drarf_pkg::MODE_PULL : drarf_pkg::MODE_PUSH;
    q.lft     = pick_sample();
    q.rgt     = pick_sample();
    q.bframes = 15'($urandom_range(0, 32767));
    if (q.mode == drarf_pkg::MODE_PUSH && $urandom_range(0, 99) < 12) begin
      q.bstart  = 1'b1;
      q.bframes = pick_frames();
    end
    return q;
  endfunction

  task automatic drive_item(input frame_req_t req, input bit typed, input frame_res_t tres);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    drv_typed = typed;
    drv_res   = tres;
    in_tuser  = req.mode;
    in_tdata  = {req.bframes, req.bstart, req.rgt, req.lft};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // wait until nothing is in flight, then write one register
  task automatic cfg_write(input logic idx, input logic val);
    while (expected_q.size() != 0) @(negedge clk);
    cfg_addr  = idx;
    cfg_wdata = val;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // predict at input accept, check at output accept
  always @(posedge clk) begin
    frame_req_t req_bus;
    frame_res_t want;
    if (!rst_n) begin
      pred_reset();
    end else begin
      if (cfg_we) begin
        if (cfg_addr[0] == drarf_pkg::REG_FAST_FORWARD) ff_q = cfg_wdata[0];
        else mute_q = cfg_wdata[0];
      end
      if (in_tvalid && in_tready) begin
        req_bus = {in_tuser[0], in_tdata};
        resample_step(req_bus, want);
        if (drv_typed) want = drv_res;
        expected_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch('0, out_tdata);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata !== want) report_mismatch(want, out_tdata);
        end
      end
    end
  end

  // output stalls: mostly short, a few long
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    drv_typed = 1'b0;
    drv_res   = '0;
    build_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_tbl[i]) begin
      drive_item(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].res);
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 300 == 0) begin
        cfg_write(drarf_pkg::REG_FAST_FORWARD, 1'($urandom_range(0, 1)));
        cfg_write(drarf_pkg::REG_MUTED, 1'($urandom_range(0, 1)));
      end
      drive_item(rand_req(), 1'b0, '0);
    end
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
